### src/prc_pkg.sv
package prc_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic               closes_polygon;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_u;
    logic signed [31:0] out_v;
    logic               last_vertex;
    logic               empty_polygon;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] u;
    logic [31:0] v;
  } vtx_t;

  typedef enum logic [1:0] {
    MUL_DB_R = 2'd0,
    MUL_M1_D = 2'd1,
    MUL_DU_T = 2'd2,
    MUL_DV_T = 2'd3
  } mul_op_t;

  localparam logic [2:0] STG_TOP    = 3'd0;
  localparam logic [2:0] STG_BOTTOM = 3'd1;
  localparam logic [2:0] STG_LEFT   = 3'd2;
  localparam logic [2:0] STG_RIGHT  = 3'd3;
  localparam logic [2:0] STG_SINK   = 3'd4;

  localparam logic [1:0] CFG_TOP    = 2'd0;
  localparam logic [1:0] CFG_BOTTOM = 2'd1;
  localparam logic [1:0] CFG_LEFT   = 2'd2;
  localparam logic [1:0] CFG_RIGHT  = 2'd3;

  localparam logic [31:0] CLIP_TOP_RST    = 32'd0;
  localparam logic [31:0] CLIP_BOTTOM_RST = 32'd10420224;
  localparam logic [31:0] CLIP_LEFT_RST   = 32'd0;
  localparam logic [31:0] CLIP_RIGHT_RST  = 32'd15663104;

  localparam logic [31:0] FX_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [2:0] stage;
    logic       load_in;
    logic       seed;
    logic       load_edge;
    logic       load_close;
    logic       eval;
    logic       pass_k;
    logic       push;
    logic       pop;
    logic [1:0] sidx;
    logic       div_start;
    logic       div_sel;
    logic       take_t;
    logic       take_r;
    logic       mul_en;
    mul_op_t    mul_op;
    logic       cross_done;
    logic       final_acc;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [3:0] started;
    logic       ii;
    logic       ki;
    logic       div_done;
    logic       out_free;
    logic       final_emits;
  } stat_t;

endpackage

### src/prc_divider.sv
module prc_divider import prc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);

  localparam int Steps = 48;
  localparam int CntW  = $clog2(Steps);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [31:0]     rem;
  logic [47:0]     dq;
  logic [31:0]     dmag;
  logic            neg;
  logic            zden;
  logic [32:0]     sh;
  logic            qbit;

  assign sh   = {rem, dq[47]};
  assign qbit = (sh >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(Steps - 1);
        rem  <= '0;
        dq   <= {(num[31] ? (~num + 32'd1) : num), 16'd0};
        dmag <= den[31] ? (~den + 32'd1) : den;
        neg  <= num[31] ^ den[31];
        zden <= (den == 32'd0);
      end else if (busy) begin
        rem <= qbit ? 32'(sh - {1'b0, dmag}) : sh[31:0];
        dq  <= {dq[46:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // only the low 32 quotient bits survive, so negating them is exact
  always_comb begin
    if (zden) quo = '0;
    else if (neg) quo = ~dq[31:0] + 32'd1;
    else quo = dq[31:0];
  end

endmodule

### src/prc_datapath.sv
module prc_datapath import prc_pkg::*; #(
  parameter int MAX_OUT_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item
);

  localparam int CntW = $clog2(MAX_OUT_VERTICES + 1);

  logic [31:0] clip_top, clip_bottom, clip_left, clip_right;
  vtx_t        cur, ei, ek, held;
  vtx_t        first [4];
  vtx_t        prev  [4];
  vtx_t        stack [4];
  logic [3:0]  started;
  logic [31:0] da, db, dd, du, dv, bound_r;
  logic [31:0] t_r, r_r, m1, boff, mu, mv;
  logic        held_valid, drop;
  logic [CntW-1:0] count;

  logic [1:0]  s;
  logic        on_y;
  logic [31:0] bound, ei_a, ek_a, ei_b, ek_b;
  logic        cnt_full, emit_held;
  logic        div_done;
  logic [31:0] div_q, div_num;
  logic [31:0] ma, mb;
  logic signed [63:0] prod;
  logic [31:0] mres;

  assign s    = cmd.stage[1:0];
  assign on_y = ~cmd.stage[1];

  always_comb begin
    unique case (s)
      2'd0:    bound = clip_top;
      2'd1:    bound = clip_bottom;
      2'd2:    bound = clip_left;
      default: bound = clip_right;
    endcase
  end

  assign ei_a = on_y ? ei.y : ei.x;
  assign ek_a = on_y ? ek.y : ek.x;
  assign ei_b = on_y ? ei.x : ei.y;
  assign ek_b = on_y ? ek.x : ek.y;

  // top and left keep a value on the bound, bottom and right do not
  assign stat.ii = cmd.stage[0] ? ($signed(ei_a) < $signed(bound))
                                : ($signed(ei_a) >= $signed(bound));
  assign stat.ki = cmd.stage[0] ? ($signed(ek_a) < $signed(bound))
                                : ($signed(ek_a) >= $signed(bound));

  assign cnt_full         = (count >= CntW'(MAX_OUT_VERTICES));
  assign emit_held        = cmd.final_acc && !cnt_full && held_valid;
  assign stat.final_emits = !cnt_full && held_valid;
  assign stat.out_free    = !out_valid || !out_stall;
  assign stat.started     = started;
  assign stat.div_done    = div_done;

  assign div_num = cmd.div_sel ? FX_ONE : dd;

  prc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (da),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    unique case (cmd.mul_op)
      MUL_DB_R: begin ma = db; mb = r_r; end
      MUL_M1_D: begin ma = m1; mb = dd;  end
      MUL_DU_T: begin ma = du; mb = t_r; end
      default:  begin ma = dv; mb = t_r; end
    endcase
  end

  assign prod = $signed(ma) * $signed(mb);
  assign mres = prod[47:16];

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TOP:    clip_top    <= cfg_data;
        CFG_BOTTOM: clip_bottom <= cfg_data;
        CFG_LEFT:   clip_left   <= cfg_data;
        default:    clip_right  <= cfg_data;
      endcase
    end
    if (rst) begin
      clip_top    <= CLIP_TOP_RST;
      clip_bottom <= CLIP_BOTTOM_RST;
      clip_left   <= CLIP_LEFT_RST;
      clip_right  <= CLIP_RIGHT_RST;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur <= '{x: in_item.pos_x, y: in_item.pos_y, u: in_item.tex_u, v: in_item.tex_v};
    end
    if (cmd.seed) begin
      first[s] <= cur;
      prev[s]  <= cur;
    end
    if (cmd.load_edge) begin
      ei      <= prev[s];
      ek      <= cur;
      prev[s] <= cur;
    end
    if (cmd.load_close) begin
      ei <= prev[s];
      ek <= first[s];
    end
    if (cmd.eval) begin
      da      <= ek_a - ei_a;
      db      <= ek_b - ei_b;
      dd      <= bound - ei_a;
      du      <= ek.u - ei.u;
      dv      <= ek.v - ei.v;
      bound_r <= bound;
    end
    if (cmd.pass_k) cur <= ek;
    if (cmd.push) stack[cmd.sidx] <= ek;
    if (cmd.pop) cur <= stack[cmd.sidx];
    if (cmd.take_t && div_done) t_r <= div_q;
    if (cmd.take_r && div_done) r_r <= div_q;
    if (cmd.mul_en) begin
      unique case (cmd.mul_op)
        MUL_DB_R: m1   <= mres;
        MUL_M1_D: boff <= mres;
        MUL_DU_T: mu   <= mres;
        default:  mv   <= mres;
      endcase
    end
    if (cmd.cross_done) begin
      if (on_y) begin
        cur.y <= bound_r;
        cur.x <= ei.x + boff;
      end else begin
        cur.x <= bound_r;
        cur.y <= ei.y + boff;
      end
      cur.u <= ei.u + mu;
      cur.v <= ei.v + mv;
    end
    if (cmd.final_acc && !cnt_full) held <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= '0;
      held_valid <= 1'b0;
      drop       <= 1'b0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.seed) started[s] <= 1'b1;
      if (cmd.load_close) started[s] <= 1'b0;
      if (cmd.final_acc) begin
        if (cnt_full) begin
          drop <= 1'b1;
        end else begin
          held_valid <= 1'b1;
          count      <= count + 1'b1;
        end
      end
      if (cmd.finish) begin
        held_valid <= 1'b0;
        drop       <= 1'b0;
        count      <= '0;
      end
      if (emit_held || cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_held) begin
      out_item <= '{out_x: held.x, out_y: held.y, out_u: held.u, out_v: held.v,
                    last_vertex: 1'b0, empty_polygon: 1'b0, overflow: 1'b0};
    end else if (cmd.finish) begin
      if (held_valid) begin
        out_item <= '{out_x: held.x, out_y: held.y, out_u: held.u, out_v: held.v,
                      last_vertex: 1'b1, empty_polygon: 1'b0, overflow: drop};
      end else begin
        out_item <= '{out_x: '0, out_y: '0, out_u: '0, out_v: '0,
                      last_vertex: 1'b1, empty_polygon: 1'b1, overflow: drop};
      end
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (emit_held || cmd.finish) |-> !(out_valid && out_stall))
    else $error("result written over a stalled item");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MAX_OUT_VERTICES))
    else $error("vertex count past cap");

endmodule

### src/prc_ctrl.sv
module prc_ctrl import prc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_closes,
  input  stat_t stat,
  output logic  in_stall,
  output cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_STEP  = 15'h0002,
    S_EVAL  = 15'h0004,
    S_XD1   = 15'h0008,
    S_XW1   = 15'h0010,
    S_XD2   = 15'h0020,
    S_XW2   = 15'h0040,
    S_XM1   = 15'h0080,
    S_XM2   = 15'h0100,
    S_XM3   = 15'h0200,
    S_XM4   = 15'h0400,
    S_XFIN  = 15'h0800,
    S_NEXT  = 15'h1000,
    S_CLOSE = 15'h2000,
    S_FIN   = 15'h4000
  } state_t;

  state_t     state, state_next;
  logic [2:0] stg, stg_next;
  logic [2:0] cstg, cstg_next;
  logic       close_pend, close_pend_next;
  logic [2:0] sp, sp_next;
  logic [2:0] tags [4];
  logic [2:0] sp_dec;

  assign in_stall = (state != S_IDLE);
  assign sp_dec   = sp - 3'd1;

  always_comb begin
    state_next      = state;
    stg_next        = stg;
    cstg_next       = cstg;
    close_pend_next = close_pend;
    sp_next         = sp;
    cmd             = '0;
    cmd.stage       = stg;
    cmd.mul_op      = MUL_DB_R;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in     = 1'b1;
          stg_next        = STG_TOP;
          cstg_next       = STG_TOP;
          close_pend_next = in_closes;
          state_next      = S_STEP;
        end
      end
      S_STEP: begin
        if (stg == STG_SINK) begin
          if (!stat.final_emits || stat.out_free) begin
            cmd.final_acc = 1'b1;
            state_next    = S_NEXT;
          end
        end else if (!stat.started[stg[1:0]]) begin
          cmd.seed   = 1'b1;
          state_next = S_NEXT;
        end else begin
          cmd.load_edge = 1'b1;
          state_next    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.ii && stat.ki) begin
          cmd.pass_k = 1'b1;
          stg_next   = stg + 3'd1;
          state_next = S_STEP;
        end else if (!stat.ii && !stat.ki) begin
          state_next = S_NEXT;
        end else begin
          // entering edge: the end vertex follows the crossing downstream
          if (stat.ki) begin
            cmd.push = 1'b1;
            cmd.sidx = sp[1:0];
            sp_next  = sp + 3'd1;
          end
          state_next = S_XD1;
        end
      end
      S_XD1: begin
        cmd.div_start = 1'b1;
        state_next    = S_XW1;
      end
      S_XW1: begin
        cmd.take_t = 1'b1;
        if (stat.div_done) state_next = S_XD2;
      end
      S_XD2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = S_XW2;
      end
      S_XW2: begin
        cmd.take_r = 1'b1;
        if (stat.div_done) state_next = S_XM1;
      end
      S_XM1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_DB_R;
        state_next = S_XM2;
      end
      S_XM2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_M1_D;
        state_next = S_XM3;
      end
      S_XM3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_DU_T;
        state_next = S_XM4;
      end
      S_XM4: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_DV_T;
        state_next = S_XFIN;
      end
      S_XFIN: begin
        cmd.cross_done = 1'b1;
        stg_next       = stg + 3'd1;
        state_next     = S_STEP;
      end
      S_NEXT: begin
        if (sp != 3'd0) begin
          cmd.pop    = 1'b1;
          cmd.sidx   = sp_dec[1:0];
          stg_next   = tags[sp_dec[1:0]];
          sp_next    = sp_dec;
          state_next = S_STEP;
        end else if (close_pend) begin
          state_next = S_CLOSE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLOSE: begin
        cmd.stage = cstg;
        if (cstg == STG_SINK) begin
          state_next = S_FIN;
        end else if (stat.started[cstg[1:0]]) begin
          cmd.load_close = 1'b1;
          stg_next       = cstg;
          cstg_next      = cstg + 3'd1;
          state_next     = S_EVAL;
        end else begin
          cstg_next = cstg + 3'd1;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish      = 1'b1;
          close_pend_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stg        <= STG_TOP;
      cstg       <= STG_TOP;
      close_pend <= 1'b0;
      sp         <= 3'd0;
    end else begin
      state      <= state_next;
      stg        <= stg_next;
      cstg       <= cstg_next;
      close_pend <= close_pend_next;
      sp         <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) tags[sp[1:0]] <= stg + 3'd1;
  end

  a_sp_range: assert property (@(posedge clk) disable iff (rst) sp <= 3'd4)
    else $error("vertex stack overrun");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (sp == 3'd0))
    else $error("stack not drained at idle");

endmodule

### src/polygon_rect_clipper.sv
// Clips textured polygons (signed 16.16 x, y, u, v) against a screen
// rectangle, top, bottom, left and right in turn. One vertex item is taken
// at a time; closes_polygon on an item ends its polygon, and the clipped
// polygon streams out one vertex behind, the last one flagged last_vertex.
// A polygon clipped away entirely gives one item with empty_polygon set.
// Past MAX_OUT_VERTICES kept vertices the rest are dropped and overflow is
// raised on the last item. Bounds may be written between items.
// Each stage that an item reaches adds to its cost; every edge crossing
// adds two 48-step divisions on the one shared iterative divider.
// Output stalls add their own wait.
module polygon_rect_clipper import prc_pkg::*; #(
  parameter int MAX_OUT_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  prc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_closes (in_item.closes_polygon),
    .stat      (stat),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  prc_datapath #(
    .MAX_OUT_VERTICES (MAX_OUT_VERTICES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
